/* rtl/vaq_pkg.sv */
// Package for the vertex attribute quantizer.
// Holds the item structs, register indexes and quantizer constants.
// No dependencies.
package vaq_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BOX_MIN_X    = 3'd0,
		REG_BOX_MIN_Y    = 3'd1,
		REG_BOX_MIN_Z    = 3'd2,
		REG_BOX_EXTENT_X = 3'd3,
		REG_BOX_EXTENT_Y = 3'd4,
		REG_BOX_EXTENT_Z = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic               tangent_positive;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} in_t;

	typedef struct packed {
		logic [31:0] packed_position;
		logic [31:0] packed_normal;
		logic [31:0] packed_tangent_tex;
		logic        degenerate_vector;
	} out_t;

	// Position code widths per axis
	localparam int POS_BITS [3] = '{11, 11, 10};
	// Magnitude bits of each snorm code: normal xyz, tangent xyz
	localparam int SN_NB [6] = '{7, 7, 7, 6, 5, 5};
	// Quotient bits of the position divider
	localparam int DIV_STEPS = 11;
	localparam int TEX_ONE = 4096;

endpackage

/* rtl/vertex_attribute_quantizer.sv */
// Vertex attribute quantizer top level: full streaming pipeline.
// Depends on vaq_pkg.
//
// Takes one vertex per item and returns one item of three packed words.
// The stages: input stage, setup stage, eleven divider and search
// stages, output register. One item per cycle is sustained without stalls.
// Position uses a restoring divider, one quotient bit per stage; the unit
// vector codes come from a bit-per-stage search built on shift-add
// updates of (2k-1)^2*L. Each stage advances when its successor has room,
// so bubbles close up and input is taken while a result waits.
// Box registers must only be written while no item is in flight.
module vertex_attribute_quantizer
	import vaq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef struct packed {
		logic [2:0][31:0] ud;
		logic [2:0]       lo;
		logic [2:0]       hi;
		logic [5:0][30:0] sq;
		logic [5:0]       neg;
		logic [1:0][9:0]  tex;
		logic             hand;
	} s1_t;

	typedef struct packed {
		logic [2:0][44:0] rem;
		logic [2:0][32:0] dvs;
		logic [2:0][10:0] q;
		logic [2:0]       lo;
		logic [2:0]       hi;
		logic [5:0][51:0] acc_a;
		logic [5:0][51:0] acc_b;
		logic [5:0][45:0] rhs;
		logic [5:0][6:0]  k;
		logic [5:0]       neg;
		logic [1:0][31:0] len;
		logic [1:0]       zlen;
		logic [1:0][9:0]  tex;
		logic             hand;
	} work_t;

	localparam int NW = DIV_STEPS + 1;

	logic [2:0][31:0] box_min_q;
	logic [2:0][31:0] box_ext_q;

	s1_t   d_s1;
	logic  v_s1;
	work_t wk_s [NW];
	logic  v_s  [NW];
	out_t  out_q;
	logic  vo_q;

	logic  go_1;
	logic  go_w [NW];
	logic  go_o;

	s1_t   s1_d;
	work_t s2_d;
	out_t  out_d;

	// One divider bit and one search bit per component
	function automatic work_t step_f(work_t w, int i);
		work_t r;
		logic [44:0] sh;
		logic signed [51:0] t;
		logic signed [51:0] ln;
		int j;
		r = w;
		for (int a = 0; a < 3; a++) begin
			sh = 45'(w.dvs[a]) << (DIV_STEPS - 1 - i);
			if (w.rem[a] >= sh) begin
				r.rem[a] = w.rem[a] - sh;
				r.q[a][4'(DIV_STEPS - 1 - i)] = 1'b1;
			end
		end
		for (int c = 0; c < 6; c++) begin
			if (i < SN_NB[c]) begin
				j  = SN_NB[c] - 1 - i;
				ln = $signed({20'b0, w.len[(c < 3) ? 0 : 1]});
				t  = $signed(w.acc_a[c]) + ($signed(w.acc_b[c]) <<< (j + 2))
					+ (ln <<< (2 * j + 2));
				if (t <= $signed({6'b0, w.rhs[c]})) begin
					r.acc_a[c] = t;
					r.acc_b[c] = $signed(w.acc_b[c]) + (ln <<< (j + 1));
					r.k[c][3'(j)] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q <= '0;
			box_ext_q <= {3{32'd65536}};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_MIN_X:    box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y:    box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z:    box_min_q[2] <= cfg_data;
				REG_BOX_EXTENT_X: box_ext_q[0] <= cfg_data;
				REG_BOX_EXTENT_Y: box_ext_q[1] <= cfg_data;
				REG_BOX_EXTENT_Z: box_ext_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance each stage when its successor has room
	assign go_o = !vo_q || out_ready;
	assign go_w[NW-1] = !v_s[NW-1] || go_o;
	for (genvar g = 0; g < NW - 1; g++) begin : g_go
		assign go_w[g] = !v_s[g] || go_w[g+1];
	end
	assign go_1 = !v_s1 || go_w[0];
	assign in_ready = go_1;

	// Stage 1: box offset, squares, texcoord codes
	always_comb begin
		logic signed [32:0] dd [3];
		logic signed [31:0] pp [3];
		logic signed [15:0] cc [6];
		logic signed [31:0] pr;
		logic signed [16:0] tt;
		logic [22:0] tm;
		logic signed [15:0] tr [2];
		pp[0] = in_data.pos_x;
		pp[1] = in_data.pos_y;
		pp[2] = in_data.pos_z;
		cc[0] = in_data.normal_x;
		cc[1] = in_data.normal_y;
		cc[2] = in_data.normal_z;
		cc[3] = in_data.tangent_x;
		cc[4] = in_data.tangent_y;
		cc[5] = in_data.tangent_z;
		tr[0] = in_data.tex_u;
		tr[1] = in_data.tex_v;
		s1_d = '0;
		for (int a = 0; a < 3; a++) begin
			dd[a] = 33'(pp[a]) - 33'($signed(box_min_q[a]));
			s1_d.lo[a] = dd[a][32] || (dd[a] == '0);
			s1_d.hi[a] = !s1_d.lo[a] && (dd[a][31:0] >= box_ext_q[a]);
			s1_d.ud[a] = dd[a][31:0];
		end
		for (int c = 0; c < 6; c++) begin
			pr = cc[c] * cc[c];
			s1_d.sq[c]  = pr[30:0];
			s1_d.neg[c] = cc[c][15];
		end
		// Wrap once, clamp, scale by 1023/4096 with rounding
		for (int u = 0; u < 2; u++) begin
			tt = 17'(tr[u]);
			if (tt < 0)
				tt = tt + 17'(TEX_ONE);
			else if (tt > 17'(TEX_ONE))
				tt = tt - 17'(TEX_ONE);
			if (tt < 0)
				tt = '0;
			if (tt > 17'(TEX_ONE))
				tt = 17'(TEX_ONE);
			tm = (23'(tt[12:0]) << 10) - 23'(tt[12:0]) + 23'(TEX_ONE / 2);
			s1_d.tex[u] = tm[21:12];
		end
		s1_d.hand = in_data.tangent_positive;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go_1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_1 && in_valid)
			d_s1 <= s1_d;
	end

	// Stage 2: dividend, lengths, search bounds
	always_comb begin
		logic [44:0] m;
		logic [45:0] sq46;
		s2_d = '0;
		for (int a = 0; a < 3; a++) begin
			m = (45'(d_s1.ud[a]) << POS_BITS[a]) - 45'(d_s1.ud[a]);
			s2_d.rem[a] = (m << 1) + 45'(box_ext_q[a]);
			s2_d.dvs[a] = {box_ext_q[a], 1'b0};
			s2_d.lo[a]  = d_s1.lo[a];
			s2_d.hi[a]  = d_s1.hi[a];
		end
		s2_d.len[0] = 32'(d_s1.sq[0]) + 32'(d_s1.sq[1]) + 32'(d_s1.sq[2]);
		s2_d.len[1] = 32'(d_s1.sq[3]) + 32'(d_s1.sq[4]) + 32'(d_s1.sq[5]);
		s2_d.zlen[0] = (s2_d.len[0] == '0);
		s2_d.zlen[1] = (s2_d.len[1] == '0);
		for (int c = 0; c < 6; c++) begin
			sq46 = 46'(d_s1.sq[c]);
			s2_d.rhs[c] = ((sq46 << (2 * SN_NB[c])) - (sq46 << (SN_NB[c] + 1)) + sq46) << 2;
			s2_d.acc_a[c] = {20'b0, s2_d.len[(c < 3) ? 0 : 1]};
			s2_d.acc_b[c] = 52'(-$signed({20'b0, s2_d.len[(c < 3) ? 0 : 1]}));
			s2_d.neg[c] = d_s1.neg[c];
		end
		s2_d.tex  = d_s1.tex;
		s2_d.hand = d_s1.hand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (go_w[0]) begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_w[0] && v_s1)
			wk_s[0] <= s2_d;
	end

	// Divider and search stages
	for (genvar g = 1; g < NW; g++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (go_w[g]) begin
				v_s[g] <= v_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (go_w[g] && v_s[g-1])
				wk_s[g] <= step_f(wk_s[g-1], g - 1);
		end
	end

	// Saturate, sign and pack
	always_comb begin
		logic [7:0] cn [6];
		logic [10:0] pc [3];
		work_t w;
		w = wk_s[NW-1];
		for (int a = 0; a < 3; a++) begin
			if (w.lo[a])
				pc[a] = '0;
			else if (w.hi[a])
				pc[a] = 11'((1 << POS_BITS[a]) - 1);
			else
				pc[a] = w.q[a];
		end
		for (int c = 0; c < 6; c++) begin
			if (w.zlen[(c < 3) ? 0 : 1])
				cn[c] = '0;
			else if (w.neg[c])
				cn[c] = 8'(-{1'b0, w.k[c]});
			else
				cn[c] = {1'b0, w.k[c]};
		end
		out_d.packed_position    = {pc[0], pc[1], pc[2][9:0]};
		out_d.packed_normal      = {cn[0], cn[1], cn[2], w.hand, cn[3][6:0]};
		out_d.packed_tangent_tex = {cn[4][5:0], cn[5][5:0], w.tex[0], w.tex[1]};
		out_d.degenerate_vector  = |w.zlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (go_o) begin
			vo_q <= v_s[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (go_o && v_s[NW-1])
			out_q <= out_d;
	end

	assign out_valid = vo_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_lo_hi_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((d_s1.lo & d_s1.hi) == 3'b0))
		else $error("position low and high saturation both set");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate_vector |->
		(out_data.packed_normal[31:8] == 24'h0 || out_data.packed_normal[6:0] == 7'h0))
		else $error("degenerate item carries nonzero vector code");

	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid && !out_ready |->
		(!v_s1 || !v_s[0] || !v_s[NW-1] || !go_w[0] || !go_w[NW-1] || !vo_q))
		else $error("input taken while pipeline full and stalled");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped under stall");
`endif

endmodule
